@@ rtl/core/spiwf_pkg.sv @@
// shared types and constants for the spi word framer and deframer
// request codes, framing words and state encodings; no dependencies

package spiwf_pkg;

  localparam logic [2:0] REQ_START = 3'd0;
  localparam logic [2:0] REQ_DATA  = 3'd1;
  localparam logic [2:0] REQ_END   = 3'd2;
  localparam logic [2:0] REQ_XCHG  = 3'd3;
  localparam logic [2:0] REQ_RXRST = 3'd4;
  localparam logic [2:0] REQ_CLEAR = 3'd5;

  localparam logic [15:0] HDR_ONE   = 16'h80FD;
  localparam logic [15:0] HDR_TWO   = 16'h80FE;
  localparam logic [15:0] TERM_WORD = 16'h80FF;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_PUSH = 4'b0010,
    S_OUT  = 4'b0100,
    S_EMIT = 4'b1000
  } ctl_state_t;

  typedef enum logic [2:0] {
    PH_WAIT = 3'b001,
    PH_GOT1 = 3'b010,
    PH_RECV = 3'b100
  } rx_phase_t;

endpackage

@@ rtl/core/spi_word_framer_deframer.sv @@
// spi word framer and deframer top level: transmit word fifo in a synchronous ram
// plus the header/terminator receive hunter; uses spiwf_pkg
//
// usage: one request per input transaction on in_valid/in_stall (frame start, payload
// word, frame end, exchange, receiver reset, clear all). each request gives one result
// transaction on out_valid/out_stall; an exchange that receives the terminator gives one
// status result followed by PAYLOAD_WORDS payload results, the last with payload_last.
// sequencing: one request at a time. payload word, frame end, exchange, receiver reset and
// clear are accepted, then give their result; frame start first pushes its three words one
// per cycle through the single fifo write port. the exchange reads the fifo head in the
// accept cycle and the registered ram read places tx_word in the result cycle.
// in_stall is high from accept until the last result of that request is taken.
// reset: fifo indices zero, receiver hunting for header1, payload store zero. the fifo
// ram has no reset and needs no clearing pass: only written entries are ever read.
// receiver stall: results hold steady and no new request is taken until it clears.

module spi_word_framer_deframer #(
  parameter int FIFO_DEPTH    = 2048,
  parameter int PAYLOAD_WORDS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_req_type,
  input  logic [10:0] in_block_size,
  input  logic [15:0] in_data_word,
  input  logic [15:0] in_rx_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_tx_word,
  output logic        out_tx_valid,
  output logic        out_push_dropped,
  output logic [11:0] out_fifo_free,
  output logic [15:0] out_payload_word,
  output logic        out_payload_valid,
  output logic        out_payload_last
);

  localparam int AW  = $clog2(FIFO_DEPTH);
  localparam int DW  = AW + 1;
  localparam int PIW = (PAYLOAD_WORDS > 1) ? $clog2(PAYLOAD_WORDS) : 1;
  localparam logic [AW-1:0]  LAST_SLOT = AW'(FIFO_DEPTH - 1);
  localparam logic [DW-1:0]  DEPTH_D   = DW'(FIFO_DEPTH);
  localparam logic [PIW-1:0] LAST_PIDX = PIW'(PAYLOAD_WORDS - 1);

  spiwf_pkg::ctl_state_t state_r, state_nxt;
  spiwf_pkg::rx_phase_t  phase_r, phase_nxt;

  logic [AW-1:0]  wr_r, wr_nxt, rd_r, rd_nxt, wr_inc;
  logic [PIW-1:0] ridx_r, ridx_nxt, eidx_r, eidx_nxt;
  logic           emit_r, emit_nxt;
  logic           cnt_r, cnt_nxt;
  logic [10:0]    size_r, size_nxt;
  logic           drop_r, drop_nxt;
  logic           txv_r, txv_nxt;

  logic           push_en, mem_we, mem_re;
  logic [15:0]    push_data;
  logic           store_we, store_clr;
  logic [15:0]    rd_data_r;
  logic [DW-1:0]  free_w;
  logic           accept, eidx_last;

  logic [15:0] tx_mem [FIFO_DEPTH];
  logic [15:0] pl_store_r [PAYLOAD_WORDS];

  assign in_stall  = (state_r != spiwf_pkg::S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign wr_inc    = (wr_r == LAST_SLOT) ? '0 : wr_r + AW'(1);
  assign eidx_last = (eidx_r == LAST_PIDX);

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    wr_nxt    = wr_r;
    rd_nxt    = rd_r;
    ridx_nxt  = ridx_r;
    eidx_nxt  = eidx_r;
    emit_nxt  = emit_r;
    cnt_nxt   = cnt_r;
    size_nxt  = size_r;
    drop_nxt  = drop_r;
    txv_nxt   = txv_r;
    push_en   = 1'b0;
    push_data = 16'h0000;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    store_we  = 1'b0;
    store_clr = 1'b0;
    unique case (state_r)
      spiwf_pkg::S_IDLE: begin
        if (in_valid) begin
          drop_nxt  = 1'b0;
          txv_nxt   = 1'b0;
          emit_nxt  = 1'b0;
          size_nxt  = in_block_size;
          state_nxt = spiwf_pkg::S_OUT;
          unique case (in_req_type)
            spiwf_pkg::REQ_START: begin
              push_en   = 1'b1;
              push_data = spiwf_pkg::HDR_ONE;
              cnt_nxt   = 1'b0;
              state_nxt = spiwf_pkg::S_PUSH;
            end
            spiwf_pkg::REQ_DATA: begin
              push_en   = 1'b1;
              push_data = in_data_word;
            end
            spiwf_pkg::REQ_END: begin
              push_en   = 1'b1;
              push_data = spiwf_pkg::TERM_WORD;
            end
            spiwf_pkg::REQ_XCHG: begin
              if (wr_r != rd_r) begin
                mem_re  = 1'b1;
                txv_nxt = 1'b1;
                rd_nxt  = (rd_r == LAST_SLOT) ? '0 : rd_r + AW'(1);
                priority if (phase_r == spiwf_pkg::PH_RECV &&
                             in_rx_word == spiwf_pkg::TERM_WORD) begin
                  phase_nxt = spiwf_pkg::PH_WAIT;
                  emit_nxt  = 1'b1;
                end else if (phase_r == spiwf_pkg::PH_RECV) begin
                  store_we = 1'b1;
                  if (ridx_r != LAST_PIDX) begin
                    ridx_nxt = ridx_r + PIW'(1);
                  end
                end else if (phase_r == spiwf_pkg::PH_WAIT &&
                             in_rx_word == spiwf_pkg::HDR_ONE) begin
                  phase_nxt = spiwf_pkg::PH_GOT1;
                end else if (phase_r == spiwf_pkg::PH_GOT1 &&
                             in_rx_word == spiwf_pkg::HDR_TWO) begin
                  phase_nxt = spiwf_pkg::PH_RECV;
                  ridx_nxt  = '0;
                end
              end
            end
            spiwf_pkg::REQ_RXRST: begin
              phase_nxt = spiwf_pkg::PH_WAIT;
            end
            spiwf_pkg::REQ_CLEAR: begin
              wr_nxt    = '0;
              rd_nxt    = '0;
              store_clr = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      spiwf_pkg::S_PUSH: begin
        push_en   = 1'b1;
        push_data = cnt_r ? {5'b00000, size_r} : spiwf_pkg::HDR_TWO;
        cnt_nxt   = 1'b1;
        if (cnt_r) begin
          state_nxt = spiwf_pkg::S_OUT;
        end
      end
      spiwf_pkg::S_OUT: begin
        eidx_nxt = '0;
        if (!out_stall) begin
          state_nxt = emit_r ? spiwf_pkg::S_EMIT : spiwf_pkg::S_IDLE;
        end
      end
      spiwf_pkg::S_EMIT: begin
        if (!out_stall) begin
          if (eidx_last) begin
            state_nxt = spiwf_pkg::S_IDLE;
            emit_nxt  = 1'b0;
          end else begin
            eidx_nxt = eidx_r + PIW'(1);
          end
        end
      end
      default: begin
        state_nxt = spiwf_pkg::S_IDLE;
      end
    endcase
    if (push_en) begin
      if (wr_inc == rd_r) begin
        drop_nxt = 1'b1;
      end else begin
        mem_we = 1'b1;
        wr_nxt = wr_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= spiwf_pkg::S_IDLE;
      phase_r <= spiwf_pkg::PH_WAIT;
      wr_r    <= '0;
      rd_r    <= '0;
      ridx_r  <= '0;
      eidx_r  <= '0;
      emit_r  <= 1'b0;
      cnt_r   <= 1'b0;
      drop_r  <= 1'b0;
      txv_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      wr_r    <= wr_nxt;
      rd_r    <= rd_nxt;
      ridx_r  <= ridx_nxt;
      eidx_r  <= eidx_nxt;
      emit_r  <= emit_nxt;
      cnt_r   <= cnt_nxt;
      drop_r  <= drop_nxt;
      txv_r   <= txv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    size_r <= size_nxt;
  end

  // transmit fifo ram, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      tx_mem[wr_r] <= push_data;
    end
    if (mem_re) begin
      rd_data_r <= tx_mem[rd_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || store_clr) begin
      for (int i = 0; i < PAYLOAD_WORDS; i++) begin
        pl_store_r[i] <= 16'h0000;
      end
    end else if (store_we) begin
      pl_store_r[ridx_r] <= in_rx_word;
    end
  end

  always_comb begin
    if (wr_r > rd_r) begin
      free_w = DEPTH_D - {1'b0, wr_r - rd_r};
    end else if (rd_r > wr_r) begin
      free_w = {1'b0, rd_r - wr_r - AW'(1)};
    end else begin
      free_w = DEPTH_D;
    end
  end

  assign out_valid         = (state_r == spiwf_pkg::S_OUT) || (state_r == spiwf_pkg::S_EMIT);
  assign out_tx_word       = txv_r ? rd_data_r : 16'h0000;
  assign out_tx_valid      = txv_r;
  assign out_push_dropped  = drop_r;
  assign out_fifo_free     = 12'(free_w);
  assign out_payload_valid = (state_r == spiwf_pkg::S_EMIT);
  assign out_payload_word  = out_payload_valid ? pl_store_r[eidx_r] : 16'h0000;
  assign out_payload_last  = out_payload_valid ? eidx_last : !emit_r;

  a_no_accept_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !out_valid)
    else $error("request taken while a result is pending");

  a_push_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |=> (wr_r != rd_r))
    else $error("fifo empty right after a word was written");

  a_xchg_sends: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_req_type == spiwf_pkg::REQ_XCHG && wr_r != rd_r
      |=> out_valid && out_tx_valid)
    else $error("exchange on a non-empty fifo did not send a word");

  a_last_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_payload_last |=> !in_stall)
    else $error("input still stalled after the final result");

  a_rx_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    ridx_r <= LAST_PIDX)
    else $error("receive index past the last payload slot");

endmodule

@@ dv/tb_spi_word_framer_deframer.sv @@
// self-checking testbench for spi_word_framer_deframer: directed and random requests with
// random gaps and stalls, every result checked field by field against a behavioral predictor
// depends on rtl/core/spiwf_pkg.sv and rtl/core/spi_word_framer_deframer.sv
`timescale 1ns / 1ps

module tb_spi_word_framer_deframer;

  localparam int DEPTH       = 2048;
  localparam int PW          = 16;
  localparam int QUIET_LIMIT = 5000;
  localparam int LONG_HOLD   = 600;
  localparam logic [2:0] REQ_SPARE6 = 3'd6;
  localparam logic [2:0] REQ_SPARE7 = 3'd7;

  typedef struct packed {
    logic [2:0]  req;
    logic [10:0] size;
    logic [15:0] data;
    logic [15:0] rx;
    logic        drain_first;
  } request_t;

  typedef struct packed {
    logic [15:0] tx_word;
    logic        tx_valid;
    logic        push_dropped;
    logic [11:0] fifo_free;
    logic [15:0] payload_word;
    logic        payload_valid;
    logic        payload_last;
  } status_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_req_type = '0;
  logic [10:0] in_block_size = '0;
  logic [15:0] in_data_word = '0;
  logic [15:0] in_rx_word = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_tx_word;
  logic        out_tx_valid;
  logic        out_push_dropped;
  logic [11:0] out_fifo_free;
  logic [15:0] out_payload_word;
  logic        out_payload_valid;
  logic        out_payload_last;

  spi_word_framer_deframer u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_req_type       (in_req_type),
    .in_block_size     (in_block_size),
    .in_data_word      (in_data_word),
    .in_rx_word        (in_rx_word),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_tx_word       (out_tx_word),
    .out_tx_valid      (out_tx_valid),
    .out_push_dropped  (out_push_dropped),
    .out_fifo_free     (out_fifo_free),
    .out_payload_word  (out_payload_word),
    .out_payload_valid (out_payload_valid),
    .out_payload_last  (out_payload_last)
  );

  request_t    req_queue[$];
  status_t     due_results[$];
  request_t    cur_req;
  int          queued_cnt = 0;
  int          sent_cnt = 0;
  int          taken_cnt = 0;
  int          err_cnt = 0;
  int          quiet_cnt = 0;
  int          tx_gap = 0;
  int          rx_gap = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  bit          tx_calm = 1'b0;
  bit          rx_calm = 1'b0;

  // framer state mirror
  logic [15:0]          m_fifo [DEPTH];
  int                   m_wr = 0;
  int                   m_rd = 0;
  spiwf_pkg::rx_phase_t m_phase = spiwf_pkg::PH_WAIT;
  int                   m_idx = 0;
  logic [15:0]          m_payload [PW];

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic logic fifo_push(input logic [15:0] w);
    if ((m_wr + 1) % DEPTH == m_rd) return 1'b0;
    m_fifo[m_wr] = w;
    m_wr = (m_wr + 1) % DEPTH;
    return 1'b1;
  endfunction

  function automatic logic [11:0] fifo_space();
    if (m_wr > m_rd) return 12'(DEPTH - (m_wr - m_rd));
    if (m_rd > m_wr) return 12'(m_rd - m_wr - 1);
    return 12'(DEPTH);
  endfunction

  function automatic void apply_request(input request_t r);
    logic [15:0] txw;
    logic        txv;
    logic        drop;
    logic        emit;
    status_t     res;
    int          n;
    txw  = '0;
    txv  = 1'b0;
    drop = 1'b0;
    emit = 1'b0;
    case (r.req)
      spiwf_pkg::REQ_START: begin
        if (!fifo_push(spiwf_pkg::HDR_ONE)) drop = 1'b1;
        if (!fifo_push(spiwf_pkg::HDR_TWO)) drop = 1'b1;
        if (!fifo_push({5'd0, r.size})) drop = 1'b1;
      end
      spiwf_pkg::REQ_DATA: begin
        if (!fifo_push(r.data)) drop = 1'b1;
      end
      spiwf_pkg::REQ_END: begin
        if (!fifo_push(spiwf_pkg::TERM_WORD)) drop = 1'b1;
      end
      spiwf_pkg::REQ_XCHG: begin
        if (m_wr != m_rd) begin
          txw  = m_fifo[m_rd];
          txv  = 1'b1;
          m_rd = (m_rd + 1) % DEPTH;
          if (m_phase == spiwf_pkg::PH_RECV && r.rx == spiwf_pkg::TERM_WORD) begin
            m_phase = spiwf_pkg::PH_WAIT;
            emit    = 1'b1;
          end else if (m_phase == spiwf_pkg::PH_RECV) begin
            m_payload[m_idx] = r.rx;
            if (m_idx < PW - 1) m_idx++;
          end else if (m_phase == spiwf_pkg::PH_WAIT && r.rx == spiwf_pkg::HDR_ONE) begin
            m_phase = spiwf_pkg::PH_GOT1;
          end else if (m_phase == spiwf_pkg::PH_GOT1 && r.rx == spiwf_pkg::HDR_TWO) begin
            m_phase = spiwf_pkg::PH_RECV;
            m_idx   = 0;
          end
        end
      end
      spiwf_pkg::REQ_RXRST: begin
        m_phase = spiwf_pkg::PH_WAIT;
      end
      spiwf_pkg::REQ_CLEAR: begin
        m_wr = 0;
        m_rd = 0;
        for (int i = 0; i < PW; i++) m_payload[i] = '0;
      end
      default: begin
      end
    endcase
    n = emit ? PW + 1 : 1;
    for (int k = 0; k < n; k++) begin
      res.tx_word       = txw;
      res.tx_valid      = txv;
      res.push_dropped  = drop;
      res.fifo_free     = fifo_space();
      res.payload_word  = (k == 0) ? 16'd0 : m_payload[k - 1];
      res.payload_valid = (k != 0);
      res.payload_last  = (k == n - 1);
      due_results.push_back(res);
    end
  endfunction

  function automatic int pick_gap(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [15:0] pick_rx();
    case ($urandom_range(0, 19))
      0: return spiwf_pkg::HDR_ONE;
      1: return spiwf_pkg::HDR_TWO;
      2: return spiwf_pkg::TERM_WORD;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic queue_req(input logic [2:0] rq, input logic [10:0] sz, input logic [15:0] dw,
                           input logic [15:0] rw, input bit drain);
    request_t r;
    r.req         = rq;
    r.size        = sz;
    r.data        = dw;
    r.rx          = rw;
    r.drain_first = drain;
    req_queue.push_back(r);
    queued_cnt++;
  endtask

  task automatic queue_rand(input logic [2:0] rq, input logic [15:0] rw, input bit drain);
    queue_req(rq, 11'($urandom_range(0, 2045)), 16'($urandom_range(0, 65535)), rw, drain);
  endtask

  // one frame pushed, then exchanged back with the partner sending a frame; a broken one gets at most one flaw
  task automatic queue_frame(input bit broken);
    int n;
    int flaw;
    int r;
    int cut;
    r    = $urandom_range(0, 99);
    n    = (r < 70) ? $urandom_range(0, 6) : (r < 95) ? $urandom_range(7, 16)
                                                      : $urandom_range(17, 24);
    flaw = broken ? $urandom_range(0, 4) : -1;
    cut  = $urandom_range(0, n);
    queue_req(spiwf_pkg::REQ_START,
              ($urandom_range(0, 3) == 0) ? 11'($urandom_range(0, 2045)) : 11'(n),
              16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
              $urandom_range(0, 3) == 0);
    for (int i = 0; i < n; i++) begin
      queue_rand(spiwf_pkg::REQ_DATA, 16'($urandom_range(0, 65535)), 1'b0);
    end
    queue_rand(spiwf_pkg::REQ_END, 16'($urandom_range(0, 65535)), 1'b0);
    queue_rand(spiwf_pkg::REQ_XCHG, spiwf_pkg::HDR_ONE, 1'b0);
    if (flaw == 0) queue_rand(spiwf_pkg::REQ_XCHG, 16'($urandom_range(0, 65535)), 1'b0);
    queue_rand(spiwf_pkg::REQ_XCHG, spiwf_pkg::HDR_TWO, 1'b0);
    for (int i = 0; i < n; i++) begin
      if (i == cut && flaw == 1) queue_rand(spiwf_pkg::REQ_RXRST, pick_rx(), 1'b0);
      if (i == cut && flaw == 2) queue_rand(spiwf_pkg::REQ_CLEAR, pick_rx(), 1'b0);
      queue_rand(spiwf_pkg::REQ_XCHG, ($urandom_range(0, 15) == 0) ? pick_rx()
                                      : 16'($urandom_range(0, 65535)), 1'b0);
    end
    if (flaw != 3) queue_rand(spiwf_pkg::REQ_XCHG, spiwf_pkg::TERM_WORD, 1'b0);
    if (flaw == 4) queue_rand(spiwf_pkg::REQ_XCHG, spiwf_pkg::TERM_WORD, 1'b0);
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      err_cnt++;
      $display("%0t: %s mismatch expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        apply_request(cur_req);
        sent_cnt++;
        if (sent_cnt % 64 == 0) tx_calm = ($urandom_range(0, 3) == 0);
        tx_gap = pick_gap(tx_calm);
      end
      if (in_valid && in_stall) begin
      end else if (tx_gap > 0) begin
        tx_gap--;
        in_valid <= 1'b0;
      end else if (req_queue.size() > 0 &&
                   !(req_queue[0].drain_first && due_results.size() > 0)) begin
        cur_req = req_queue.pop_front();
        in_valid      <= 1'b1;
        in_req_type   <= cur_req.req;
        in_block_size <= cur_req.size;
        in_data_word  <= cur_req.data;
        in_rx_word    <= cur_req.rx;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result stall generator with one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!hold_done && taken_cnt >= 120) begin
      hold_done = 1'b1;
      hold_left = LONG_HOLD;
      out_stall <= 1'b1;
    end else if (rx_gap > 0) begin
      rx_gap--;
      out_stall <= 1'b1;
    end else begin
      rx_gap = pick_gap(rx_calm);
      out_stall <= (rx_gap > 0);
      if (rx_gap > 0) rx_gap--;
    end
  end

  // result monitor
  always @(posedge clk) begin
    status_t want;
    if (rst_n && out_valid && !out_stall) begin
      taken_cnt++;
      if (taken_cnt % 64 == 0) rx_calm = ($urandom_range(0, 3) == 0);
      if (due_results.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result tx_word %0h payload_word %0h", $time, out_tx_word,
                 out_payload_word);
      end else begin
        want = due_results.pop_front();
        check_field("tx_word", want.tx_word, out_tx_word);
        check_field("tx_valid", want.tx_valid, out_tx_valid);
        check_field("push_dropped", want.push_dropped, out_push_dropped);
        check_field("fifo_free", want.fifo_free, out_fifo_free);
        check_field("payload_word", want.payload_word, out_payload_word);
        check_field("payload_valid", want.payload_valid, out_payload_valid);
        check_field("payload_last", want.payload_last, out_payload_last);
      end
    end
  end

  // watchdog on handshake activity
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cnt = 0;
    end else begin
      quiet_cnt++;
      if (quiet_cnt >= QUIET_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    int  base;
    int  kind;
    bit  filled;
    filled = 1'b0;
    for (int i = 0; i < PW; i++) m_payload[i] = '0;

    // directed
    queue_req(spiwf_pkg::REQ_XCHG, 11'd0, 16'd0, spiwf_pkg::HDR_ONE, 1'b0);
    queue_req(REQ_SPARE6, 11'h7FF, 16'hFFFF, 16'hFFFF, 1'b0);
    queue_req(REQ_SPARE7, 11'd0, 16'd0, 16'd0, 1'b0);
    queue_req(spiwf_pkg::REQ_START, 11'd0, 16'd0, 16'd0, 1'b0);
    queue_req(spiwf_pkg::REQ_DATA, 11'd0, 16'h0000, 16'd0, 1'b0);
    queue_req(spiwf_pkg::REQ_DATA, 11'h7FF, 16'hFFFF, 16'hFFFF, 1'b0);
    queue_req(spiwf_pkg::REQ_END, 11'd0, 16'd0, 16'd0, 1'b0);
    queue_req(spiwf_pkg::REQ_START, 11'd2045, 16'd0, 16'd0, 1'b0);
    queue_req(spiwf_pkg::REQ_XCHG, 11'd0, 16'd0, spiwf_pkg::HDR_ONE, 1'b0);
    queue_req(spiwf_pkg::REQ_XCHG, 11'd0, 16'd0, 16'h1234, 1'b0);
    queue_req(spiwf_pkg::REQ_XCHG, 11'd0, 16'd0, spiwf_pkg::HDR_TWO, 1'b0);
    queue_req(spiwf_pkg::REQ_XCHG, 11'd0, 16'd0, 16'hFFFF, 1'b0);
    queue_req(spiwf_pkg::REQ_XCHG, 11'd0, 16'd0, 16'h0000, 1'b0);
    queue_req(spiwf_pkg::REQ_XCHG, 11'd0, 16'd0, spiwf_pkg::TERM_WORD, 1'b0);
    queue_req(spiwf_pkg::REQ_XCHG, 11'd0, 16'd0, spiwf_pkg::HDR_ONE, 1'b0);
    queue_req(spiwf_pkg::REQ_RXRST, 11'd0, 16'd0, 16'd0, 1'b0);
    queue_req(spiwf_pkg::REQ_DATA, 11'd0, 16'hA5A5, 16'd0, 1'b0);
    queue_req(spiwf_pkg::REQ_CLEAR, 11'd0, 16'd0, 16'd0, 1'b0);
    queue_req(spiwf_pkg::REQ_XCHG, 11'd0, 16'd0, spiwf_pkg::HDR_ONE, 1'b0);

    // random
    base = queued_cnt;
    queue_rand(REQ_SPARE6, 16'd0, 1'b1);
    while (queued_cnt - base < 360) begin
      if (!filled && queued_cnt - base >= 150) begin
        // fill the fifo to full, drop pushes, then wrap the write index
        filled = 1'b1;
        queue_rand(spiwf_pkg::REQ_CLEAR, pick_rx(), 1'b1);
        for (int i = 0; i < DEPTH / 3 + 1; i++) begin
          queue_rand(spiwf_pkg::REQ_START, pick_rx(), 1'b0);
        end
        for (int i = 0; i < 2; i++) queue_rand(spiwf_pkg::REQ_DATA, pick_rx(), 1'b0);
        queue_rand(spiwf_pkg::REQ_END, pick_rx(), 1'b0);
        for (int i = 0; i < 4; i++) queue_rand(spiwf_pkg::REQ_XCHG, pick_rx(), 1'b0);
        for (int i = 0; i < 6; i++) queue_rand(spiwf_pkg::REQ_DATA, pick_rx(), 1'b0);
        queue_rand(spiwf_pkg::REQ_CLEAR, pick_rx(), 1'b0);
        base = base + (DEPTH / 3 + 1) + 15;
      end
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
        queue_frame(1'b0);
      end else if (kind < 8) begin
        queue_frame(1'b1);
      end else begin
        repeat ($urandom_range(1, 6)) queue_rand(3'($urandom_range(0, 7)), pick_rx(), 1'b0);
      end
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    while (sent_cnt < queued_cnt) @(posedge clk);
    while (due_results.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (err_cnt == 0 && due_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/spiwf_pkg.sv
rtl/core/spi_word_framer_deframer.sv
dv/tb_spi_word_framer_deframer.sv
